// ===== sv/tdfe_pkg.sv =====
// Shared types and constants of the transition-table state machine.
package tdfe_pkg;

  // Command codes carried by an input word
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EVENT   = 2'd1,
    CMD_SET_TMO = 2'd2,
    CMD_START   = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_INIT_STATE  = 1'b1;

  localparam int unsigned CFG_DATA_W = 8;

  // One transition table entry (53 bits)
  typedef struct packed {
    logic [7:0]  event_code;
    logic [7:0]  src_state;
    logic [7:0]  dst_state;
    logic [15:0] timeout;
    logic        guarded;
    logic [2:0]  sel;
    logic        expect_val;
    logic [7:0]  action;
  } entry_t;

  // Command token that walks the cell chain
  typedef struct packed {
    cmd_e        cmd;
    logic [4:0]  slot;
    logic [7:0]  event_code;
    logic [7:0]  from_state;
    logic [7:0]  to_state;
    logic [15:0] tmo;
    logic        has_guard;
    logic [2:0]  guard_select;
    logic        guard_expect;
    logic [7:0]  action_id;
    logic [7:0]  conds;
    logic [7:0]  state;
    logic        hit;
    logic [15:0] res_tmo;
    logic [7:0]  res_act;
  } token_t;

  // Result word
  typedef struct packed {
    logic        status;
    logic [7:0]  current_state;
    logic [15:0] timeout_out;
    logic [7:0]  action_out;
  } result_t;

endpackage

// ===== sv/tdfe_if.sv =====
// Valid/ready channel interfaces for command words and result words.
interface tdfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  entry_index;
  logic [7:0]  event_code;
  logic [7:0]  from_state;
  logic [7:0]  to_state;
  logic [15:0] timeout_seconds;
  logic        has_guard;
  logic [2:0]  guard_select;
  logic        guard_expect;
  logic [7:0]  action_id;
  logic [7:0]  condition_bits;

  modport source (
    output valid, command, entry_index, event_code, from_state, to_state,
           timeout_seconds, has_guard, guard_select, guard_expect, action_id,
           condition_bits,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, event_code, from_state, to_state,
           timeout_seconds, has_guard, guard_select, guard_expect, action_id,
           condition_bits,
    output ready
  );
endinterface

interface tdfe_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  current_state;
  logic [15:0] timeout_out;
  logic [7:0]  action_out;

  modport source (
    output valid, status, current_state, timeout_out, action_out,
    input  ready
  );
  modport sink (
    input  valid, status, current_state, timeout_out, action_out,
    output ready
  );
endinterface

// ===== sv/table_driven_fsm_engine_unit.sv =====
// Top level of the programmable transition-table state machine.
// Each command word walks a chain of TABLE_DEPTH cells, one cell per cycle,
// and every cell holds one table entry; the first matching cell claims the
// word. The result leaves the last cell for a holding register and moves on
// into the output register once that is free or being read. One command is
// in the chain at a time; the next is accepted as soon as the previous result
// has moved to the output register, even while that result still waits to be
// taken. Table entries are undefined until loaded and there is no clearing
// pass after reset.
module table_driven_fsm_engine_unit #(
  parameter int TABLE_DEPTH = 32,
  parameter int COND_BITS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tdfe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tdfe_in_if.sink                       in_i,
  tdfe_out_if.source                    out_o
);

  logic [5:0]        entry_count_q;
  logic [7:0]        init_state_q;
  logic [7:0]        state_q;
  logic              busy_q;
  logic              pend_valid_q;
  tdfe_pkg::result_t pend_q, pend_d;
  logic              out_valid_q;
  tdfe_pkg::result_t out_q;
  logic              accept;
  logic              out_free;
  tdfe_pkg::token_t  issue;
  tdfe_pkg::token_t  tok   [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0] tok_v;
  tdfe_pkg::token_t  tail;
  logic              is_search;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      init_state_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tdfe_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_wdata_i[5:0];
        tdfe_pkg::CFG_INIT_STATE:  init_state_q  <= cfg_wdata_i[7:0];
        default:                   entry_count_q <= entry_count_q;
      endcase
    end
  end

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;

  // Build the token for an accepted command
  always_comb begin
    issue.cmd          = tdfe_pkg::cmd_e'(in_i.command);
    issue.slot         = in_i.entry_index;
    issue.event_code   = in_i.event_code;
    issue.from_state   = in_i.from_state;
    issue.to_state     = in_i.to_state;
    issue.tmo          = in_i.timeout_seconds;
    issue.has_guard    = in_i.has_guard;
    issue.guard_select = in_i.guard_select;
    issue.guard_expect = in_i.guard_expect;
    issue.action_id    = in_i.action_id;
    issue.conds        = in_i.condition_bits;
    issue.state        = (issue.cmd == tdfe_pkg::CMD_START) ? init_state_q : state_q;
    issue.hit          = 1'b0;
    issue.res_tmo      = '0;
    issue.res_act      = '0;
  end

  assign tok[0]   = issue;
  assign tok_v[0] = accept;

  // Chain of entry cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    tdfe_cell #(
      .CELL_IDX  (g),
      .COND_BITS (COND_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .entry_count_i (entry_count_q),
      .tok_valid_i   (tok_v[g]),
      .tok_i         (tok[g]),
      .tok_valid_o   (tok_v[g+1]),
      .tok_o         (tok[g+1])
    );
  end

  assign tail      = tok[TABLE_DEPTH];
  assign is_search = (tail.cmd == tdfe_pkg::CMD_EVENT) ||
                     (tail.cmd == tdfe_pkg::CMD_SET_TMO);

  // Form the result word from the token leaving the chain
  always_comb begin
    pend_d.status        = is_search && !tail.hit;
    pend_d.current_state = tail.state;
    pend_d.timeout_out   = tail.res_tmo;
    pend_d.action_out    = tail.res_act;
  end

  assign out_free = !out_valid_q || out_o.ready;

  // Control: busy flag, holding register, output register, present state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (tok_v[TABLE_DEPTH]) begin
        pend_valid_q <= 1'b1;
        state_q      <= tail.state;
      end
      if (pend_valid_q && out_free) begin
        pend_valid_q <= 1'b0;
        busy_q       <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (tok_v[TABLE_DEPTH]) begin
      pend_q <= pend_d;
    end
    if (pend_valid_q && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.current_state = out_q.current_state;
  assign out_o.timeout_out   = out_q.timeout_out;
  assign out_o.action_out    = out_q.action_out;

  // At most one command in flight across the chain and holding register
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_v[TABLE_DEPTH:1], pend_valid_q}))
    else $error("more than one command in flight");

  // A held result or a token in the chain always belongs to a busy engine
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q || (|tok_v[TABLE_DEPTH:1])) |-> busy_q)
    else $error("command in flight while engine idle");

  // The token leaving the chain never finds the holding register occupied
  a_tail_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_v[TABLE_DEPTH] |-> !pend_valid_q)
    else $error("result overwrote a held result");

endmodule

// ===== sv/tdfe_cell.sv =====
// One chain cell: holds one table entry and processes the passing token.
module tdfe_cell #(
  parameter int CELL_IDX  = 0,
  parameter int COND_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [5:0]       entry_count_i,
  input  logic             tok_valid_i,
  input  tdfe_pkg::token_t tok_i,
  output logic             tok_valid_o,
  output tdfe_pkg::token_t tok_o
);

  tdfe_pkg::entry_t entry_q, entry_d;
  tdfe_pkg::token_t tok_q, tok_d;
  logic             valid_q;
  logic             entry_we;
  logic             active;
  logic             cond_bit;
  logic             guard_ok;

  // Entry takes part in searches only below the entry count
  assign active = (int'(entry_count_i) > CELL_IDX);

  // Guard test; a condition bit beyond the implemented range reads as 0
  always_comb begin
    cond_bit = 1'b0;
    if (int'(entry_q.sel) < COND_BITS) begin
      cond_bit = tok_i.conds[entry_q.sel];
    end
  end
  assign guard_ok = !entry_q.guarded || (cond_bit == entry_q.expect_val);

  // Apply the token to this entry
  always_comb begin
    tok_d    = tok_i;
    entry_d  = entry_q;
    entry_we = 1'b0;
    case (tok_i.cmd)
      tdfe_pkg::CMD_LOAD: begin
        if (int'(tok_i.slot) == CELL_IDX) begin
          entry_we           = 1'b1;
          entry_d.event_code = tok_i.event_code;
          entry_d.src_state  = tok_i.from_state;
          entry_d.dst_state  = tok_i.to_state;
          entry_d.timeout    = tok_i.tmo;
          entry_d.guarded    = tok_i.has_guard;
          entry_d.sel        = tok_i.guard_select;
          entry_d.expect_val = tok_i.guard_expect;
          entry_d.action     = tok_i.action_id;
        end
      end
      tdfe_pkg::CMD_EVENT: begin
        if (active && !tok_i.hit && (entry_q.event_code == tok_i.event_code) &&
            (entry_q.src_state == tok_i.state) && guard_ok) begin
          tok_d.hit     = 1'b1;
          tok_d.state   = entry_q.dst_state;
          tok_d.res_tmo = entry_q.timeout;
          tok_d.res_act = entry_q.action;
        end
      end
      tdfe_pkg::CMD_SET_TMO: begin
        if (active && !tok_i.hit && (entry_q.dst_state == tok_i.to_state)) begin
          tok_d.hit       = 1'b1;
          entry_we        = 1'b1;
          entry_d.timeout = tok_i.tmo;
        end
      end
      default: begin
        tok_d = tok_i;
      end
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    if (tok_valid_i && entry_we) begin
      entry_q <= entry_d;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

endmodule

// ===== dv/table_driven_fsm_engine_unit_tb.sv =====
// Testbench for the transition-table state machine: directed table plus random words.
`timescale 1ns / 100ps

module table_driven_fsm_engine_unit_tb;

  localparam int unsigned TABLE_DEPTH    = 32;
  localparam int unsigned LATENCY        = TABLE_DEPTH + 2;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASES         = 7;
  localparam int unsigned PHASE_WORDS    = 150;
  localparam logic [7:0]  TICK_EVENT     = 8'hFF;

  // One command word as the sender presents it
  typedef struct packed {
    tdfe_pkg::cmd_e command;
    logic [4:0]     slot;
    logic [7:0]     event_code;
    logic [7:0]     from_state;
    logic [7:0]     to_state;
    logic [15:0]    tmo;
    logic           has_guard;
    logic [2:0]     guard_sel;
    logic           guard_val;
    logic [7:0]     action;
    logic [7:0]     conds;
  } fsm_cmd_t;

  // One transition row as the predictor keeps it
  typedef struct packed {
    logic [7:0]  event_code;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] tmo;
    logic        guarded;
    logic [2:0]  sel;
    logic        expect_val;
    logic [7:0]  action;
  } fsm_row_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  // One line of the directed table
  typedef struct packed {
    row_kind_e         kind;
    fsm_cmd_t          word;
    logic              reg_idx;
    logic [7:0]        reg_val;
    logic              pinned;
    tdfe_pkg::result_t result;
  } stim_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic                            cfg_idx_i;
  logic [tdfe_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  tdfe_in_if  cmd_if ();
  tdfe_out_if res_if ();

  table_driven_fsm_engine_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cmd_if),
    .out_o       (res_if)
  );

  // Predictor state
  fsm_row_t    fsm_table [TABLE_DEPTH];
  logic [7:0]  fsm_state;
  logic [5:0]  fsm_entry_count;
  logic [7:0]  fsm_init_state;

  tdfe_pkg::result_t result_q [$];
  stim_row_t         directed_rows [$];
  logic [7:0]        count_plan [PHASES];
  logic              pinned_valid;
  tdfe_pkg::result_t pinned_result;
  logic              steady;
  int unsigned       err_count;
  int unsigned       idle_cycles;
  fsm_cmd_t          seen_word;
  tdfe_pkg::result_t due;

  // Free-running clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the predicted machine by one command word and return its result word
  function automatic tdfe_pkg::result_t fsm_advance(fsm_cmd_t w);
    tdfe_pkg::result_t r;
    int unsigned       n;
    int unsigned       i;
    logic              guard_hold;
    r = '0;
    n = (fsm_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : fsm_entry_count;
    case (w.command)
      tdfe_pkg::CMD_LOAD: begin
        fsm_table[w.slot] = '{w.event_code, w.from_state, w.to_state, w.tmo,
                              w.has_guard, w.guard_sel, w.guard_val, w.action};
      end
      tdfe_pkg::CMD_EVENT: begin
        r.status = 1'b1;
        for (i = 0; i < n; i++) begin
          guard_hold = !fsm_table[5'(i)].guarded ||
                       (w.conds[fsm_table[5'(i)].sel] == fsm_table[5'(i)].expect_val);
          if (r.status && fsm_table[5'(i)].event_code == w.event_code &&
              fsm_table[5'(i)].src == fsm_state && guard_hold) begin
            fsm_state     = fsm_table[5'(i)].dst;
            r.timeout_out = fsm_table[5'(i)].tmo;
            r.action_out  = fsm_table[5'(i)].action;
            r.status      = 1'b0;
          end
        end
      end
      tdfe_pkg::CMD_SET_TMO: begin
        r.status = 1'b1;
        for (i = 0; i < n; i++) begin
          if (r.status && fsm_table[5'(i)].dst == w.to_state) begin
            fsm_table[5'(i)].tmo = w.tmo;
            r.status             = 1'b0;
          end
        end
      end
      default: begin
        fsm_state = fsm_init_state;
      end
    endcase
    r.current_state = fsm_state;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Mostly short gaps, a few long ones, none in a steady phase
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_state();
    if ($urandom_range(0, 9) == 0) return 8'hFF;
    return 8'($urandom_range(0, 5));
  endfunction

  function automatic logic [7:0] pick_event();
    if ($urandom_range(0, 4) == 0) return TICK_EVENT;
    return 8'($urandom_range(0, 3));
  endfunction

  function automatic fsm_cmd_t noise_word();
    fsm_cmd_t w;
    w.command    = tdfe_pkg::cmd_e'($urandom_range(0, 3));
    w.slot       = 5'($urandom);
    w.event_code = 8'($urandom);
    w.from_state = 8'($urandom);
    w.to_state   = 8'($urandom);
    w.tmo        = 16'($urandom);
    w.has_guard  = 1'($urandom);
    w.guard_sel  = 3'($urandom);
    w.guard_val  = 1'($urandom);
    w.action     = 8'($urandom);
    w.conds      = 8'($urandom);
    return w;
  endfunction

  // Load a row drawn from a small state and event alphabet so that events hit
  function automatic fsm_cmd_t random_load(logic [4:0] slot);
    fsm_cmd_t w;
    w            = noise_word();
    w.command    = tdfe_pkg::CMD_LOAD;
    w.slot       = slot;
    w.event_code = pick_event();
    w.from_state = pick_state();
    w.to_state   = pick_state();
    w.has_guard  = ($urandom_range(0, 9) < 4);
    if ($urandom_range(0, 6) == 0) w.action = 8'h00;
    return w;
  endfunction

  function automatic fsm_cmd_t random_word();
    fsm_cmd_t    w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w = noise_word();
    if (r < 50) begin
      w.command    = tdfe_pkg::CMD_EVENT;
      w.event_code = pick_event();
    end else if (r < 68) begin
      w = random_load(5'($urandom));
    end else if (r < 78) begin
      w.command  = tdfe_pkg::CMD_SET_TMO;
      w.to_state = pick_state();
    end else if (r < 86) begin
      w.command = tdfe_pkg::CMD_START;
    end
    return w;
  endfunction

  function automatic stim_row_t word_row(tdfe_pkg::cmd_e c, logic [4:0] s, logic [7:0] ev,
                                         logic [7:0] from, logic [7:0] to,
                                         logic [15:0] t, logic g, logic [2:0] gs,
                                         logic gv, logic [7:0] act, logic [7:0] cb);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WORD;
    row.word = '{c, s, ev, from, to, t, g, gs, gv, act, cb};
    return row;
  endfunction

  function automatic stim_row_t pin(stim_row_t row, logic st, logic [7:0] cs,
                                    logic [15:0] t, logic [7:0] act);
    row.pinned = 1'b1;
    row.result = '{st, cs, t, act};
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic idx, logic [7:0] val);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Present one word after a random gap and hold it until it is taken
  task automatic send_word(fsm_cmd_t w, logic pin_on, tdfe_pkg::result_t pin_res);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.command         = w.command;
    cmd_if.entry_index     = w.slot;
    cmd_if.event_code      = w.event_code;
    cmd_if.from_state      = w.from_state;
    cmd_if.to_state        = w.to_state;
    cmd_if.timeout_seconds = w.tmo;
    cmd_if.has_guard       = w.has_guard;
    cmd_if.guard_select    = w.guard_sel;
    cmd_if.guard_expect    = w.guard_val;
    cmd_if.action_id       = w.action;
    cmd_if.condition_bits  = w.conds;
    pinned_valid           = pin_on;
    pinned_result          = pin_res;
    cmd_if.valid           = 1'b1;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and hold until every outstanding result word has come back
  task automatic settle();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == tdfe_pkg::CFG_ENTRY_COUNT) fsm_entry_count = val[5:0];
    else fsm_init_state = val;
  endtask

  // Predict on every accepted command word, check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (cmd_if.valid && cmd_if.ready) begin
        idle_cycles = 0;
        seen_word = '{tdfe_pkg::cmd_e'(cmd_if.command), cmd_if.entry_index,
                      cmd_if.event_code, cmd_if.from_state, cmd_if.to_state,
                      cmd_if.timeout_seconds, cmd_if.has_guard, cmd_if.guard_select,
                      cmd_if.guard_expect, cmd_if.action_id, cmd_if.condition_bits};
        due = fsm_advance(seen_word);
        if (pinned_valid) due = pinned_result;
        result_q.push_back(due);
      end
      if (res_if.valid && res_if.ready) begin
        idle_cycles = 0;
        if (result_q.size() == 0) begin
          $error("result word with nothing outstanding");
          err_count++;
        end else begin
          due = result_q.pop_front();
          check_field("status", 16'(due.status), 16'(res_if.status));
          check_field("current_state", 16'(due.current_state),
                      16'(res_if.current_state));
          check_field("timeout_out", due.timeout_out, res_if.timeout_out);
          check_field("action_out", 16'(due.action_out), 16'(res_if.action_out));
        end
      end
    end
  end

  // Stall the result side at random
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    res_if.ready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (steady || stall_left == 0) begin
        res_if.ready = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end else begin
        res_if.ready = 1'b0;
        stall_left--;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned k;
    stim_row_t   row;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = tdfe_pkg::CFG_ENTRY_COUNT;
    cfg_wdata_i            = '0;
    cmd_if.valid           = 1'b0;
    cmd_if.command         = tdfe_pkg::CMD_LOAD;
    cmd_if.entry_index     = '0;
    cmd_if.event_code      = '0;
    cmd_if.from_state      = '0;
    cmd_if.to_state        = '0;
    cmd_if.timeout_seconds = '0;
    cmd_if.has_guard       = 1'b0;
    cmd_if.guard_select    = '0;
    cmd_if.guard_expect    = 1'b0;
    cmd_if.action_id       = '0;
    cmd_if.condition_bits  = '0;
    pinned_valid           = 1'b0;
    pinned_result          = '0;
    steady                 = 1'b0;
    err_count              = 0;
    idle_cycles            = 0;
    fsm_state              = '0;
    fsm_entry_count        = '0;
    fsm_init_state         = '0;
    count_plan = '{8'd32, 8'hFF, 8'd1, 8'd17, 8'd40, 8'd0, 8'd5};

    // Directed table: empty table, loads at the extremes, guards, misses, tick
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_EVENT, 5'd0, 8'h05, 8'h00, 8'h00,
                                         16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b1, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_SET_TMO, 5'd0, 8'h00, 8'h00, 8'h00,
                                         16'hFFFF, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b1, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_START, 5'd0, 8'h00, 8'h00, 8'h00,
                                         16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b0, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_LOAD, 5'd0, 8'h01, 8'h00, 8'hFF,
                                         16'hFFFF, 1'b0, 3'd0, 1'b0, 8'hFF, 8'h00),
                                1'b0, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_LOAD, 5'd1, TICK_EVENT, 8'hFF, 8'h00,
                                         16'h0000, 1'b1, 3'd7, 1'b1, 8'h00, 8'h00),
                                1'b0, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_LOAD, 5'd2, TICK_EVENT, 8'hFF, 8'h10,
                                         16'h1234, 1'b1, 3'd0, 1'b0, 8'h5A, 8'h00),
                                1'b0, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_LOAD, 5'd3, 8'h01, 8'h10, 8'h20,
                                         16'h0100, 1'b0, 3'd0, 1'b0, 8'h01, 8'h00),
                                1'b0, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_LOAD, 5'd31, 8'hFF, 8'hFF, 8'hFF,
                                         16'hFFFF, 1'b1, 3'd7, 1'b1, 8'hFF, 8'hFF),
                                1'b0, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_LOAD, 5'd4, 8'h00, 8'h20, 8'hFF,
                                         16'h0001, 1'b1, 3'd3, 1'b1, 8'h80, 8'h00),
                                1'b0, 8'h00, 16'h0000, 8'h00));
    directed_rows.push_back(reg_row(tdfe_pkg::CFG_ENTRY_COUNT, 8'd5));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_EVENT, 5'd0, 8'h01, 8'h00, 8'h00,
                                         16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b0, 8'hFF, 16'hFFFF, 8'hFF));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_EVENT, 5'd0, TICK_EVENT, 8'h00, 8'h00,
                                     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00));
    directed_rows.push_back(reg_row(tdfe_pkg::CFG_INIT_STATE, 8'hFF));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_START, 5'd0, 8'h00, 8'h00, 8'h00,
                                         16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b0, 8'hFF, 16'h0000, 8'h00));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_EVENT, 5'd0, TICK_EVENT, 8'h00, 8'h00,
                                     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h80));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_EVENT, 5'd0, 8'h01, 8'h00, 8'h00,
                                     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_EVENT, 5'd0, 8'h07, 8'h00, 8'h00,
                                         16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b1, 8'hFF, 16'h0000, 8'h00));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_SET_TMO, 5'd0, 8'h00, 8'h00, 8'h10,
                                     16'hBEEF, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_SET_TMO, 5'd0, 8'h00, 8'h00, 8'h77,
                                         16'h4321, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b1, 8'hFF, 16'h0000, 8'h00));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_EVENT, 5'd0, TICK_EVENT, 8'h00, 8'h00,
                                     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h01));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_EVENT, 5'd0, TICK_EVENT, 8'h00, 8'h00,
                                     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_EVENT, 5'd0, 8'h01, 8'h00, 8'h00,
                                     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00));
    directed_rows.push_back(word_row(tdfe_pkg::CMD_EVENT, 5'd0, 8'h00, 8'h00, 8'h00,
                                     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h08));
    directed_rows.push_back(reg_row(tdfe_pkg::CFG_ENTRY_COUNT, 8'd0));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_EVENT, 5'd0, TICK_EVENT, 8'h00, 8'h00,
                                         16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'hFF),
                                1'b1, 8'hFF, 16'h0000, 8'h00));
    directed_rows.push_back(reg_row(tdfe_pkg::CFG_INIT_STATE, 8'h00));
    directed_rows.push_back(pin(word_row(tdfe_pkg::CMD_START, 5'd0, 8'h00, 8'h00, 8'h00,
                                         16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 8'h00),
                                1'b0, 8'h00, 16'h0000, 8'h00));

    // Hold reset, then release it away from the active edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table; register writes wait for the block to go idle
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_word(row.word, row.pinned, row.result);
      end
    end

    // Fill every slot while nothing is searched, so no unwritten row is ever read
    for (k = 0; k < TABLE_DEPTH; k++) send_word(random_load(5'(k)), 1'b0, '0);

    // Random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      settle();
      steady = (p == 3);
      write_reg(tdfe_pkg::CFG_ENTRY_COUNT, count_plan[3'(p)]);
      write_reg(tdfe_pkg::CFG_INIT_STATE,
                (p == 1) ? 8'hFF : (p == 2) ? 8'h00 : pick_state());
      for (k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 49) == 0) settle();
        send_word(random_word(), 1'b0, '0);
      end
    end

    // Drain, then watch for stray result words
    settle();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
